[sv/path_change_list_dedup_append_macros.svh]
// assertion helpers for the change list block
// both expect clk and arst_n in the enclosing module
`ifndef PATH_CHANGE_LIST_DEDUP_APPEND_MACROS_SVH
`define PATH_CHANGE_LIST_DEDUP_APPEND_MACROS_SVH
`ifndef SYNTHESIS
`define PCL_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
`define PCL_ASSERT_NEXT(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) else $error(msg);
`else
`define PCL_ASSERT(lbl, prop, msg)
`define PCL_ASSERT_NEXT(lbl, pre, post, msg)
`endif
`endif

[sv/pcl_pkg.sv]
package pcl_pkg;

	// request word
	typedef struct packed {
		logic [1:0]  command;
		logic [15:0] file_id;
		logic        internal_file;
		logic        last_id;
		logic [7:0]  read_index;
	} in_word_t;

	// response word
	typedef struct packed {
		logic [1:0] status;
		logic       path_added;
		logic [7:0] file_count;
		logic [8:0] list_length;
		logic [7:0] read_data;
	} out_word_t;

	// command codes
	localparam logic [1:0] CMD_ADD   = 2'd0;
	localparam logic [1:0] CMD_CLEAR = 2'd1;
	localparam logic [1:0] CMD_READ  = 2'd2;

	// status codes
	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_NEAR = 2'd1;
	localparam logic [1:0] ST_FULL = 2'd2;
	localparam logic [1:0] ST_BAD  = 2'd3;

	// path ids
	localparam logic [15:0] ROOT_ID  = 16'h3F00;
	localparam logic [15:0] BL_FIRST = 16'hA001;
	localparam logic [15:0] BL_LAST  = 16'hA004;
	localparam logic [7:0]  DELIM_HI = 8'h3F;

	typedef enum logic [2:0] {
		S_IDLE,
		S_READ,
		S_CHECK,
		S_WALK,
		S_DECIDE,
		S_WRITE,
		S_RESP
	} state_t;

endpackage

[sv/pcl_ram.sv]
module pcl_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[sv/path_change_list_dedup_append.sv]
// one request word at a time; read and clear each answer with one response word, a path id
// word without last_id is taken and gives no response
// a finished path is checked, then each stored path is walked and compared with the packed
// path, both on the single ram read port, and unless the path is skipped its packed bytes are appended
// reset clears the count, sets the list end to one and drops a partial path; ram not swept
`include "path_change_list_dedup_append_macros.svh"

module path_change_list_dedup_append #(
	parameter int STORE_BYTES = 256,
	parameter int PATH_BYTES  = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_stall,
	input  pcl_pkg::in_word_t   req,
	output logic                rsp_valid,
	input  logic                rsp_stall,
	output pcl_pkg::out_word_t  rsp
);

	localparam int MAX_IDS = (PATH_BYTES - 2) / 2;
	localparam int AW      = $clog2(STORE_BYTES);
	localparam int POS_W   = $clog2(STORE_BYTES + 1);
	localparam int LEN_W   = $clog2(PATH_BYTES + 1);
	localparam int PW      = ((POS_W > LEN_W) ? POS_W : LEN_W) + 1;
	localparam int SCW     = $clog2(MAX_IDS + 1);
	localparam int IW      = (MAX_IDS > 1) ? $clog2(MAX_IDS) : 1;

	localparam logic [PW-1:0]  S_P    = PW'(STORE_BYTES);
	localparam logic [PW-1:0]  NEAR_P = PW'(2 * PATH_BYTES);
	localparam logic [SCW-1:0] MAX_P  = SCW'(MAX_IDS);

	pcl_pkg::state_t state_q, state_d;

	logic [7:0]       count_q;
	logic [POS_W-1:0] end_q;
	logic [SCW-1:0]   staged_q;
	logic             bad_q;
	logic             root0_q;
	logic             bl1_q;
	logic [15:0]      staging_q [MAX_IDS];

	logic [PW-1:0] p_q, k_q, k_s1, wlen_q;
	logic          v_s1, wdone_q, cmp_q, dup_q;
	logic [7:0]    i_q;

	logic [1:0] status_q;
	logic       added_q;
	logic [7:0] rd_q;
	logic       rd_oor_q, rd_cnt_q;

	logic               rsp_valid_q;
	pcl_pkg::out_word_t rsp_q;

	logic             ram_we, ram_re;
	logic [AW-1:0]    ram_waddr, ram_raddr;
	logic [7:0]       ram_wdata, ram_rdata;

	logic          accept, out_free;
	logic [PW-1:0] plen, room, walk_pos, pos_s1, p_new, end_new, wlen_n;
	logic          skip_bl, w_act, w_even, w_bound, w_fail, w_end_now, wdone_n;
	logic          c_mis, c_hit, cmp_n, path_end, walk_last, no_room, wr_last, finish_clr;
	logic [PW-1:0] pk_k, pk_id;
	logic [15:0]   pk_sel;
	logic [7:0]    pk_byte;

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// byte store
	pcl_ram #(
		.WIDTH (8),
		.DEPTH (STORE_BYTES)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// handshake and shared sums
	always_comb begin
		accept    = req_valid && !req_stall;
		out_free  = !rsp_valid_q || !rsp_stall;
		plen      = PW'({staged_q, 1'b0}) + PW'(2);
		skip_bl   = (PW'(staged_q) == PW'(2)) && root0_q && bl1_q;
		room      = S_P - p_q;
		no_room   = room < plen;
		walk_pos  = p_q + k_q;
		end_new   = p_q + plen - PW'(2);
		wr_last   = (k_q == plen - PW'(1));
		walk_last = ((i_q + 8'd1) == count_q);
	end

	// packed path byte: staged ids high byte first, then the root delimiter
	always_comb begin
		pk_k   = (state_q == pcl_pkg::S_WRITE) ? k_q : k_s1;
		pk_id  = pk_k >> 1;
		pk_sel = staging_q[pk_id[IW-1:0]];
		if (pk_id < PW'(staged_q)) begin
			pk_byte = pk_k[0] ? pk_sel[7:0] : pk_sel[15:8];
		end else begin
			pk_byte = pk_k[0] ? pcl_pkg::ROOT_ID[7:0] : pcl_pkg::ROOT_ID[15:8];
		end
	end

	// walk and compare on the byte returned by the ram
	always_comb begin
		pos_s1    = p_q + k_s1;
		w_act     = v_s1 && !wdone_q && (state_q == pcl_pkg::S_WALK);
		w_even    = !k_s1[0];
		w_bound   = (pos_s1 + PW'(1)) >= S_P;
		w_fail    = w_act && w_even &&
		            (w_bound || ((k_s1 == '0) && (ram_rdata != pcl_pkg::DELIM_HI)));
		w_end_now = w_act && w_even && !w_bound && (k_s1 != '0) &&
		            (ram_rdata == pcl_pkg::DELIM_HI);
		wdone_n   = wdone_q || w_end_now;
		wlen_n    = w_end_now ? k_s1 : wlen_q;
		c_mis     = v_s1 && cmp_q && (ram_rdata != pk_byte);
		c_hit     = v_s1 && cmp_q && !c_mis && (k_s1 == plen - PW'(1));
		cmp_n     = cmp_q && !c_mis && !c_hit;
		path_end  = v_s1 && (state_q == pcl_pkg::S_WALK) && !w_fail && wdone_n && !cmp_n;
		p_new     = p_q + wlen_n;
	end

	// staging is dropped whenever a path finishes or the list is cleared
	always_comb begin
		finish_clr = (accept && (req.command == pcl_pkg::CMD_CLEAR)) ||
		             ((state_q == pcl_pkg::S_CHECK) && bad_q) ||
		             ((state_q == pcl_pkg::S_WALK) && w_fail) ||
		             ((state_q == pcl_pkg::S_DECIDE) && (no_room || skip_bl || dup_q)) ||
		             ((state_q == pcl_pkg::S_WRITE) && wr_last);
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			pcl_pkg::S_IDLE: begin
				if (accept) begin
					case (req.command)
						pcl_pkg::CMD_ADD:   state_d = req.last_id ? pcl_pkg::S_CHECK : pcl_pkg::S_IDLE;
						pcl_pkg::CMD_CLEAR: state_d = pcl_pkg::S_RESP;
						pcl_pkg::CMD_READ:  state_d = pcl_pkg::S_READ;
						default:            state_d = pcl_pkg::S_IDLE;
					endcase
				end
			end
			pcl_pkg::S_READ: state_d = pcl_pkg::S_RESP;
			pcl_pkg::S_CHECK: begin
				if (bad_q) begin
					state_d = pcl_pkg::S_RESP;
				end else if (count_q == 8'd0) begin
					state_d = pcl_pkg::S_DECIDE;
				end else begin
					state_d = pcl_pkg::S_WALK;
				end
			end
			pcl_pkg::S_WALK: begin
				if (w_fail) begin
					state_d = pcl_pkg::S_RESP;
				end else if (path_end && walk_last) begin
					state_d = pcl_pkg::S_DECIDE;
				end
			end
			pcl_pkg::S_DECIDE: begin
				state_d = (no_room || skip_bl || dup_q) ? pcl_pkg::S_RESP : pcl_pkg::S_WRITE;
			end
			pcl_pkg::S_WRITE: begin
				if (wr_last) begin
					state_d = pcl_pkg::S_RESP;
				end
			end
			pcl_pkg::S_RESP: begin
				if (out_free) begin
					state_d = pcl_pkg::S_IDLE;
				end
			end
			default: state_d = pcl_pkg::S_IDLE;
		endcase
	end

	// ram ports and request stall
	always_comb begin
		req_stall = (state_q != pcl_pkg::S_IDLE);
		ram_re    = 1'b0;
		ram_raddr = walk_pos[AW-1:0];
		ram_we    = 1'b0;
		ram_waddr = walk_pos[AW-1:0];
		ram_wdata = pk_byte;
		case (state_q)
			pcl_pkg::S_IDLE: begin
				ram_re    = accept && (req.command == pcl_pkg::CMD_READ);
				ram_raddr = req.read_index[AW-1:0];
			end
			pcl_pkg::S_WALK:  ram_re = 1'b1;
			pcl_pkg::S_WRITE: ram_we = 1'b1;
			default: begin
				ram_re = 1'b0;
			end
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pcl_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// list count, list end, staging control, walk control, response valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			end_q       <= POS_W'(1);
			staged_q    <= '0;
			bad_q       <= 1'b0;
			v_s1        <= 1'b0;
			wdone_q     <= 1'b0;
			cmp_q       <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (accept && (req.command == pcl_pkg::CMD_ADD)) begin
				if (staged_q < MAX_P) begin
					staged_q <= staged_q + SCW'(1);
				end
				bad_q <= bad_q || req.internal_file || (staged_q >= MAX_P);
			end
			if (accept && (req.command == pcl_pkg::CMD_CLEAR)) begin
				count_q <= '0;
				end_q   <= POS_W'(1);
			end
			if (finish_clr) begin
				staged_q <= '0;
				bad_q    <= 1'b0;
			end
			if (state_q == pcl_pkg::S_DECIDE) begin
				end_q <= p_q[POS_W-1:0];
			end
			if ((state_q == pcl_pkg::S_WRITE) && wr_last) begin
				count_q <= count_q + 8'd1;
				end_q   <= end_new[POS_W-1:0];
			end
			v_s1 <= (state_q == pcl_pkg::S_WALK) && !path_end && !w_fail;
			if (state_q == pcl_pkg::S_CHECK) begin
				wdone_q <= 1'b0;
				cmp_q   <= (PW'(1) + plen) <= S_P;
			end else if (path_end) begin
				wdone_q <= 1'b0;
				cmp_q   <= (p_new + plen) <= S_P;
			end else if (state_q == pcl_pkg::S_WALK) begin
				wdone_q <= wdone_n;
				cmp_q   <= cmp_n;
			end
			if ((state_q == pcl_pkg::S_RESP) && out_free) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// staged ids, walk position and result fields
	always_ff @(posedge clk) begin
		if (accept && (req.command == pcl_pkg::CMD_ADD) && (staged_q < MAX_P)) begin
			staging_q[staged_q[IW-1:0]] <= req.file_id;
			if (staged_q == '0) begin
				root0_q <= (req.file_id == pcl_pkg::ROOT_ID);
			end
			if (staged_q == SCW'(1)) begin
				bl1_q <= req.file_id inside {[pcl_pkg::BL_FIRST : pcl_pkg::BL_LAST]};
			end
		end
		if (accept) begin
			status_q <= pcl_pkg::ST_OK;
			added_q  <= 1'b0;
			rd_q     <= 8'd0;
			rd_oor_q <= 9'(req.read_index) >= 9'(STORE_BYTES);
			rd_cnt_q <= (req.read_index == 8'd0);
		end
		case (state_q)
			pcl_pkg::S_READ: begin
				if (rd_oor_q) begin
					rd_q <= 8'd0;
				end else begin
					rd_q <= rd_cnt_q ? count_q : ram_rdata;
				end
			end
			pcl_pkg::S_CHECK: begin
				if (bad_q) begin
					status_q <= pcl_pkg::ST_BAD;
				end
				p_q   <= PW'(1);
				k_q   <= '0;
				i_q   <= '0;
				dup_q <= 1'b0;
			end
			pcl_pkg::S_WALK: begin
				k_s1   <= k_q;
				wlen_q <= wlen_n;
				dup_q  <= dup_q || c_hit;
				if (w_fail) begin
					status_q <= pcl_pkg::ST_BAD;
				end
				if (path_end) begin
					p_q <= p_new;
					k_q <= '0;
					i_q <= i_q + 8'd1;
				end else begin
					k_q <= k_q + PW'(1);
				end
			end
			pcl_pkg::S_DECIDE: begin
				if (no_room) begin
					status_q <= pcl_pkg::ST_FULL;
				end else begin
					status_q <= (room < NEAR_P) ? pcl_pkg::ST_NEAR : pcl_pkg::ST_OK;
				end
				k_q <= '0;
			end
			pcl_pkg::S_WRITE: begin
				k_q <= k_q + PW'(1);
				if (wr_last) begin
					added_q <= 1'b1;
				end
			end
			pcl_pkg::S_RESP: begin
				if (out_free) begin
					rsp_q.status      <= status_q;
					rsp_q.path_added  <= added_q;
					rsp_q.file_count  <= count_q;
					rsp_q.list_length <= 9'(end_q);
					rsp_q.read_data   <= rd_q;
				end
			end
			default: begin
			end
		endcase
	end

	// checks
	`PCL_ASSERT(a_end_range, (end_q != '0) && (PW'(end_q) <= S_P), "list end outside the store")
	`PCL_ASSERT(a_write_bound, !ram_we || ((walk_pos != '0) && (walk_pos < S_P)), "append write outside the store")
	`PCL_ASSERT(a_walk_count, (state_q != pcl_pkg::S_WALK) || (i_q < count_q), "walk ran past the path count")
	`PCL_ASSERT_NEXT(a_resp_load, (state_q == pcl_pkg::S_RESP) && out_free, rsp_valid_q && (state_q == pcl_pkg::S_IDLE), "response word not loaded")

endmodule

[dv/testbench.sv]
`timescale 1ns / 100ps

localparam int STORE_BYTES = 256;
localparam int PATH_BYTES  = 16;
localparam int MAX_IDS     = (PATH_BYTES - 2) / 2;
localparam int STAGE_DEPTH = PATH_BYTES / 2;
// command word the block drops without a response
localparam logic [1:0] CMD_NONE = 2'd3;

// change list image, path staging and the responses still owed by the block
class change_list_board;
	logic [7:0]  store_img [STORE_BYTES];
	logic [15:0] stage_ids [STAGE_DEPTH];
	logic [7:0]  pack_buf [PATH_BYTES];
	int unsigned stage_n;
	bit          stage_bad;
	int unsigned tail;
	pcl_pkg::out_word_t rsp_fifo [$];
	int unsigned errors, checked, appended, near_seen, full_seen, bad_seen;

	function new();
		foreach (store_img[i]) store_img[i] = '0;
		foreach (stage_ids[i]) stage_ids[i] = '0;
		stage_n = 0;
		stage_bad = 0;
		tail = 1;
		errors = 0;
		checked = 0;
		appended = 0;
		near_seen = 0;
		full_seen = 0;
		bad_seen = 0;
	endfunction

	function int pending();
		return rsp_fifo.size();
	endfunction

	function logic [15:0] id_at(int unsigned p);
		return {store_img[p], store_img[p + 1]};
	endfunction

	// walk the stored paths: append point, and whether the packed path is already there
	function bit walk_paths(input int unsigned plen, output int unsigned tail_pos,
		output bit dup);
		int unsigned p, cnt;
		logic [15:0] fid;
		bit same;
		p = 1;
		cnt = store_img[0];
		dup = 0;
		tail_pos = 0;
		for (int i = 0; i < cnt; i++) begin
			if (p + plen <= STORE_BYTES) begin
				same = 1;
				for (int k = 0; k < plen; k++)
					if (pack_buf[k] != store_img[p + k]) same = 0;
				if (same) dup = 1;
			end
			if (p + 1 >= STORE_BYTES) return 0;
			fid = id_at(p);
			p += 2;
			// a path has to open with a delimiter id
			if (fid[15:8] != pcl_pkg::DELIM_HI) return 0;
			do begin
				if (p + 1 >= STORE_BYTES) return 0;
				fid = id_at(p);
				p += 2;
			end while (fid[15:8] != pcl_pkg::DELIM_HI);
			p -= 2;
		end
		tail_pos = p;
		return 1;
	endfunction

	// finished path: check, pack, walk, then append unless skipped
	function logic [1:0] close_path(output bit added);
		int unsigned n, plen, tail_pos, room;
		bit dup, skip;
		added = 0;
		n = stage_n;
		if (stage_bad || n == 0 || n > MAX_IDS) return pcl_pkg::ST_BAD;
		for (int i = 0; i < n; i++) begin
			pack_buf[2 * i] = stage_ids[i][15:8];
			pack_buf[2 * i + 1] = stage_ids[i][7:0];
		end
		pack_buf[2 * n] = pcl_pkg::ROOT_ID[15:8];
		pack_buf[2 * n + 1] = pcl_pkg::ROOT_ID[7:0];
		plen = 2 * n + 2;
		skip = (n == 2 && stage_ids[0] == pcl_pkg::ROOT_ID &&
			stage_ids[1] >= pcl_pkg::BL_FIRST && stage_ids[1] <= pcl_pkg::BL_LAST);
		if (!walk_paths(plen, tail_pos, dup)) return pcl_pkg::ST_BAD;
		if (dup) skip = 1;
		tail = tail_pos;
		room = STORE_BYTES - tail_pos;
		// room applies to skipped paths as well
		if (room < plen) return pcl_pkg::ST_FULL;
		if (!skip) begin
			for (int k = 0; k < plen; k++) store_img[tail_pos + k] = pack_buf[k];
			store_img[0] = store_img[0] + 8'd1;
			tail = tail_pos + plen - 2;
			added = 1;
		end
		return (room < 2 * PATH_BYTES) ? pcl_pkg::ST_NEAR : pcl_pkg::ST_OK;
	endfunction

	// accepted request word: update the image and queue the response it causes
	function void note_word(pcl_pkg::in_word_t w);
		pcl_pkg::out_word_t e;
		bit added;
		e = '0;
		added = 0;
		case (w.command)
			pcl_pkg::CMD_ADD: begin
				if (w.internal_file) stage_bad = 1;
				if (stage_n < MAX_IDS) begin
					stage_ids[stage_n] = w.file_id;
					stage_n++;
				end else begin
					stage_bad = 1;
				end
				if (!w.last_id) return;
				e.status = close_path(added);
				stage_n = 0;
				stage_bad = 0;
			end
			pcl_pkg::CMD_CLEAR: begin
				store_img[0] = '0;
				tail = 1;
				stage_n = 0;
				stage_bad = 0;
			end
			pcl_pkg::CMD_READ: begin
				e.read_data = store_img[w.read_index];
			end
			default: begin
				return;
			end
		endcase
		e.path_added = added;
		e.file_count = store_img[0];
		e.list_length = 9'(tail);
		if (added) appended++;
		if (e.status == pcl_pkg::ST_NEAR) near_seen++;
		if (e.status == pcl_pkg::ST_FULL) full_seen++;
		if (e.status == pcl_pkg::ST_BAD) bad_seen++;
		rsp_fifo.push_back(e);
	endfunction

	task report(string msg);
		$display("[%0t] mismatch: %s", $time, msg);
		errors++;
	endtask

	// accepted response word against the oldest one owed
	task check_word(pcl_pkg::out_word_t got);
		pcl_pkg::out_word_t want;
		if (rsp_fifo.size() == 0) begin
			report($sformatf("response %h with nothing pending", got));
			return;
		end
		want = rsp_fifo.pop_front();
		checked++;
		if (got.status !== want.status)
			report($sformatf("rsp %0d status %0d, want %0d", checked, got.status, want.status));
		if (got.path_added !== want.path_added)
			report($sformatf("rsp %0d path_added %0d, want %0d", checked, got.path_added,
				want.path_added));
		if (got.file_count !== want.file_count)
			report($sformatf("rsp %0d file_count %0d, want %0d", checked, got.file_count,
				want.file_count));
		if (got.list_length !== want.list_length)
			report($sformatf("rsp %0d list_length %0d, want %0d", checked, got.list_length,
				want.list_length));
		if (got.read_data !== want.read_data)
			report($sformatf("rsp %0d read_data %h, want %h", checked, got.read_data,
				want.read_data));
	endtask
endclass

module testbench;
	logic               clk;
	logic               arst_n = 1'b0;
	logic               req_valid = 1'b0;
	logic               req_stall;
	pcl_pkg::in_word_t  req = '0;
	logic               rsp_valid;
	logic               rsp_stall = 1'b0;
	pcl_pkg::out_word_t rsp;

	change_list_board sb;
	logic [15:0] path_buf [$];
	int unsigned words_sent = 0;
	int unsigned quiet_left = 0;

	path_change_list_dedup_append uut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// hang guard, far above the slowest legal run
	initial begin
		#50_000_000;
		$display("timeout with %0d responses outstanding", sb.pending());
		$display("RESULT: ERROR");
		$finish;
	end

	// idle span: mostly none or short, a few long
	function automatic int gap_len();
		int r;
		r = $urandom_range(99);
		if (r < 50) return 0;
		if (r < 88) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// sender gaps, with runs of back to back words
	function automatic int send_gap();
		if (quiet_left > 0) begin
			quiet_left--;
			return 0;
		end
		if ($urandom_range(49) == 0) quiet_left = $urandom_range(20, 60);
		return gap_len();
	endfunction

	// response monitor
	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall) sb.check_word(rsp);
	end

	// receiver stalls, with calm stretches
	initial begin : rsp_side
		int hold;
		forever begin
			@(posedge clk);
			if ($urandom_range(15) == 0) begin
				rsp_stall <= 1'b0;
				repeat ($urandom_range(60, 150)) @(posedge clk);
			end
			hold = gap_len();
			if (hold > 0) begin
				rsp_stall <= 1'b1;
				repeat (hold) @(posedge clk);
			end
			rsp_stall <= 1'b0;
			repeat ($urandom_range(0, 5)) @(posedge clk);
		end
	end

	// present one word and hold it until taken
	task automatic send_word(pcl_pkg::in_word_t w);
		int gap;
		req <= w;
		req_valid <= 1'b1;
		@(posedge clk);
		while (req_stall) @(posedge clk);
		sb.note_word(w);
		if (w.command != CMD_NONE) words_sent++;
		gap = send_gap();
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// clear, read or dropped word with noise in the unused fields
	task automatic send_cmd(logic [1:0] cmd, logic [7:0] idx);
		pcl_pkg::in_word_t w;
		w.command = cmd;
		w.file_id = 16'($urandom);
		w.internal_file = 1'($urandom);
		w.last_id = 1'($urandom);
		w.read_index = idx;
		send_word(w);
	endtask

	// ids of path_buf, root first; finish marks the last one
	task automatic send_path(int internal_at, bit finish);
		pcl_pkg::in_word_t w;
		for (int i = 0; i < path_buf.size(); i++) begin
			w.command = pcl_pkg::CMD_ADD;
			w.file_id = path_buf[i];
			w.internal_file = (i == internal_at);
			w.last_id = finish && (i == path_buf.size() - 1);
			w.read_index = 8'($urandom);
			send_word(w);
		end
	endtask

	// hold the sender until every owed response is in
	task automatic drain();
		req_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0) @(posedge clk);
	endtask

	// random path: mostly rooted, short, from a small id pool so duplicates recur
	function automatic void make_path();
		int n, r;
		path_buf.delete();
		r = $urandom_range(99);
		if (r < 85) n = $urandom_range(1, 4);
		else if (r < 95) n = $urandom_range(5, 7);
		else n = $urandom_range(8, 9);
		r = $urandom_range(99);
		if (r < 90) path_buf.push_back(pcl_pkg::ROOT_ID);
		else if (r < 97) path_buf.push_back({pcl_pkg::DELIM_HI, 8'($urandom)});
		else path_buf.push_back(16'($urandom));
		for (int i = 1; i < n; i++) begin
			r = $urandom_range(99);
			if (r < 55) path_buf.push_back(16'h2F00 + 16'($urandom_range(3)));
			else if (r < 72) path_buf.push_back(pcl_pkg::BL_FIRST + 16'($urandom_range(4)));
			else if (r < 78) path_buf.push_back({pcl_pkg::DELIM_HI, 8'($urandom)});
			else path_buf.push_back(16'($urandom));
		end
	endfunction

	initial begin : stimulus
		int unsigned base, mid, r, i;
		bit paused;
		sb = new();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// one-id paths until every reachable byte is written and the list is at its end
		for (i = 1; i <= 126; i++) begin
			path_buf = '{pcl_pkg::ROOT_ID + 16'(i)};
			send_path(-1, 1);
		end

		// corners: full list, blacklist edge, duplicate, internal id, overlong path,
		// corrupt list, dropped command
		send_cmd(pcl_pkg::CMD_READ, 8'd0);
		send_cmd(pcl_pkg::CMD_READ, 8'd254);
		path_buf = '{16'h3F7F};
		send_path(-1, 1);
		path_buf = '{pcl_pkg::ROOT_ID + 16'd1};
		send_path(-1, 1);
		send_cmd(pcl_pkg::CMD_CLEAR, 8'd0);
		path_buf = '{pcl_pkg::ROOT_ID, pcl_pkg::BL_LAST};
		send_path(-1, 1);
		path_buf = '{pcl_pkg::ROOT_ID, pcl_pkg::BL_LAST + 16'd1};
		send_path(-1, 1);
		send_path(-1, 1);
		path_buf = '{pcl_pkg::ROOT_ID};
		send_path(0, 1);
		path_buf = '{pcl_pkg::ROOT_ID, 16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF,
			16'h0000, 16'h1234};
		send_path(-1, 1);
		path_buf = '{16'h1234};
		send_path(-1, 1);
		path_buf = '{pcl_pkg::ROOT_ID};
		send_path(-1, 1);
		send_cmd(CMD_NONE, 8'd255);
		send_cmd(pcl_pkg::CMD_CLEAR, 8'd0);

		// random traffic, drained once halfway
		base = words_sent;
		mid = base + 325;
		paused = 0;
		while (words_sent < base + 650) begin
			if (!paused && words_sent >= mid) begin
				drain();
				paused = 1;
			end
			r = $urandom_range(99);
			if (r < 76) begin
				make_path();
				send_path(($urandom_range(19) == 0) ? int'($urandom_range(path_buf.size() - 1))
					: -1, 1);
			end else if (r < 82) begin
				// path broken off by a clear, a read or the next path
				make_path();
				send_path(-1, 0);
				r = $urandom_range(2);
				if (r == 0) send_cmd(pcl_pkg::CMD_CLEAR, 8'($urandom));
				else if (r == 1) send_cmd(pcl_pkg::CMD_READ, 8'($urandom_range(254)));
			end else if (r < 91) begin
				send_cmd(pcl_pkg::CMD_READ, 8'($urandom_range(254)));
			end else if (r < 95) begin
				send_cmd(pcl_pkg::CMD_CLEAR, 8'($urandom));
			end else begin
				send_cmd(CMD_NONE, 8'($urandom));
			end
		end

		drain();
		repeat (600) @(posedge clk);
		$display("%0d words: store fill to the end, corner paths, random paths, reads, clears",
			words_sent);
		$display("%0d responses checked: %0d appended, %0d nearly full, %0d no room, %0d invalid",
			sb.checked, sb.appended, sb.near_seen, sb.full_seen, sb.bad_seen);
		if (sb.errors == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end
endmodule
